// File: src/jcbu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JVM compare and branch unit package
// Opcode codes and field widths shared by the unit.
// ----------------------------------------------------------------------------
package jcbu_pkg;

  localparam int unsigned CmdW = 5;
  localparam int unsigned ValW = 64;
  localparam int unsigned OffW = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_LCMP      = 5'd0,
    CMD_FCMPL     = 5'd1,
    CMD_FCMPG     = 5'd2,
    CMD_DCMPL     = 5'd3,
    CMD_DCMPG     = 5'd4,
    CMD_IFEQ      = 5'd5,
    CMD_IFNE      = 5'd6,
    CMD_IFLT      = 5'd7,
    CMD_IFGE      = 5'd8,
    CMD_IFGT      = 5'd9,
    CMD_IFLE      = 5'd10,
    CMD_IF_ICMPEQ = 5'd11,
    CMD_IF_ICMPNE = 5'd12,
    CMD_IF_ICMPLT = 5'd13,
    CMD_IF_ICMPGE = 5'd14,
    CMD_IF_ICMPGT = 5'd15,
    CMD_IF_ICMPLE = 5'd16,
    CMD_IF_ACMPEQ = 5'd17,
    CMD_IF_ACMPNE = 5'd18
  } cmd_t;

  localparam logic signed [1:0] CRES_LT = -2'sd1;
  localparam logic signed [1:0] CRES_EQ = 2'sd0;
  localparam logic signed [1:0] CRES_GT = 2'sd1;

endpackage
`default_nettype wire

// File: src/jvm_compare_branch_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JVM compare and branch unit
// Executes lcmp, fcmp, dcmp, ifXX, if_icmpXX and if_acmp bytecodes.
// ----------------------------------------------------------------------------
// Each word passes through an input register and a result register with one
// stage of compare logic between them, so the unit accepts a word every cycle
// while the output is not stalled, and each result is registered in the result
// register. Throughput is one word per cycle while out_ready holds, set by the single compare stage.
module jvm_compare_branch_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [jcbu_pkg::CmdW-1:0]    in_cmd,
  input  wire logic [jcbu_pkg::ValW-1:0]    in_value_first,
  input  wire logic [jcbu_pkg::ValW-1:0]    in_value_last,
  input  wire logic signed [jcbu_pkg::OffW-1:0] in_branch_offset,
  input  wire logic [jcbu_pkg::OffW-1:0]    in_insn_byte_offset,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [1:0]                 out_compare_result,
  output logic                              out_branch_taken,
  output logic [jcbu_pkg::OffW-1:0]         out_target_byte_offset,
  output logic                              out_target_out_of_range
);
  import jcbu_pkg::*;

  logic                   s_valid_r;
  logic [CmdW-1:0]        s_cmd_r;
  logic [ValW-1:0]        s_v1_r, s_v2_r;
  logic [OffW-1:0]        s_off_r, s_pos_r;
  logic                   s_adv;
  logic                   o_valid_r;
  logic signed [1:0]      o_cres_r, cres_nxt;
  logic                   o_taken_r, taken_nxt;
  logic [OffW-1:0]        o_tgt_r, tgt_nxt;
  logic                   o_oor_r, oor_nxt;

  assign s_adv    = !o_valid_r || out_ready;
  assign in_ready = !s_valid_r || s_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (in_ready) s_valid_r <= in_valid;
      if (s_adv) o_valid_r <= s_valid_r;
    end
    if (in_ready && in_valid) begin
      s_cmd_r <= in_cmd;
      s_v1_r  <= in_value_first;
      s_v2_r  <= in_value_last;
      s_off_r <= in_branch_offset;
      s_pos_r <= in_insn_byte_offset;
    end
    if (s_adv && s_valid_r) begin
      o_cres_r  <= cres_nxt;
      o_taken_r <= taken_nxt;
      o_tgt_r   <= tgt_nxt;
      o_oor_r   <= oor_nxt;
    end
  end

  function automatic logic signed [1:0] fp_cmp(input logic [ValW-1:0] a,
                                               input logic [ValW-1:0] b,
                                               input logic dbl,
                                               input logic nan_gt);
    logic [ValW-1:0] ka, kb;
    logic            a_nan, b_nan, zeros;
    logic signed [1:0] r;
    if (dbl) begin
      a_nan = a[62:52] == 11'h7ff && a[51:0] != '0;
      b_nan = b[62:52] == 11'h7ff && b[51:0] != '0;
      zeros = a[62:0] == '0 && b[62:0] == '0;
      ka = a[63] ? ~a : {1'b1, a[62:0]};
      kb = b[63] ? ~b : {1'b1, b[62:0]};
    end else begin
      a_nan = a[30:23] == 8'hff && a[22:0] != '0;
      b_nan = b[30:23] == 8'hff && b[22:0] != '0;
      zeros = a[30:0] == '0 && b[30:0] == '0;
      ka = {32'd0, a[31] ? ~a[31:0] : {1'b1, a[30:0]}};
      kb = {32'd0, b[31] ? ~b[31:0] : {1'b1, b[30:0]}};
    end
    if (a_nan || b_nan) r = nan_gt ? CRES_GT : CRES_LT;
    else if (zeros || ka == kb) r = CRES_EQ;
    else if (ka > kb) r = CRES_GT;
    else r = CRES_LT;
    return r;
  endfunction

  logic signed [31:0] ia, ib;
  logic signed [63:0] la, lb;
  logic signed [OffW+1:0] sum;

  assign ia  = s_v1_r[31:0];
  assign ib  = s_v2_r[31:0];
  assign la  = s_v1_r;
  assign lb  = s_v2_r;
  assign sum = $signed({2'b00, s_pos_r}) + {{2{s_off_r[OffW-1]}}, s_off_r};

  always_comb begin
    cres_nxt  = CRES_EQ;
    taken_nxt = 1'b0;
    unique case (s_cmd_r)
      CMD_LCMP:      cres_nxt = (la > lb) ? CRES_GT : ((la == lb) ? CRES_EQ : CRES_LT);
      CMD_FCMPL:     cres_nxt = fp_cmp(s_v1_r, s_v2_r, 1'b0, 1'b0);
      CMD_FCMPG:     cres_nxt = fp_cmp(s_v1_r, s_v2_r, 1'b0, 1'b1);
      CMD_DCMPL:     cres_nxt = fp_cmp(s_v1_r, s_v2_r, 1'b1, 1'b0);
      CMD_DCMPG:     cres_nxt = fp_cmp(s_v1_r, s_v2_r, 1'b1, 1'b1);
      CMD_IFEQ:      taken_nxt = ib == 0;
      CMD_IFNE:      taken_nxt = ib != 0;
      CMD_IFLT:      taken_nxt = ib < 0;
      CMD_IFGE:      taken_nxt = ib >= 0;
      CMD_IFGT:      taken_nxt = ib > 0;
      CMD_IFLE:      taken_nxt = ib <= 0;
      CMD_IF_ICMPEQ: taken_nxt = ia == ib;
      CMD_IF_ICMPNE: taken_nxt = ia != ib;
      CMD_IF_ICMPLT: taken_nxt = ia < ib;
      CMD_IF_ICMPGE: taken_nxt = ia >= ib;
      CMD_IF_ICMPGT: taken_nxt = ia > ib;
      CMD_IF_ICMPLE: taken_nxt = ia <= ib;
      CMD_IF_ACMPEQ: taken_nxt = s_v1_r == s_v2_r;
      CMD_IF_ACMPNE: taken_nxt = s_v1_r != s_v2_r;
      default: begin
        cres_nxt  = CRES_EQ;
        taken_nxt = 1'b0;
      end
    endcase
    tgt_nxt = taken_nxt ? sum[OffW-1:0] : '0;
    oor_nxt = taken_nxt && (sum[OffW+1:OffW] != 2'b00);
  end

  assign out_valid               = o_valid_r;
  assign out_compare_result      = o_cres_r;
  assign out_branch_taken        = o_taken_r;
  assign out_target_byte_offset  = o_tgt_r;
  assign out_target_out_of_range = o_oor_r;

endmodule
`default_nettype wire

// File: test/jcbu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JVM compare and branch unit checker
// Watches both channels, predicts each result from the accepted word and
// compares it field by field with what the unit returns, in order.
// ----------------------------------------------------------------------------
module jcbu_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [jcbu_pkg::CmdW-1:0]     in_cmd,
  input  wire logic [jcbu_pkg::ValW-1:0]     in_value_first,
  input  wire logic [jcbu_pkg::ValW-1:0]     in_value_last,
  input  wire logic signed [jcbu_pkg::OffW-1:0] in_branch_offset,
  input  wire logic [jcbu_pkg::OffW-1:0]     in_insn_byte_offset,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic signed [1:0]             out_compare_result,
  input  wire logic                          out_branch_taken,
  input  wire logic [jcbu_pkg::OffW-1:0]     out_target_byte_offset,
  input  wire logic                          out_target_out_of_range,
  output int                                 fail_count,
  output int                                 pending_count,
  output int                                 result_count
);
  import jcbu_pkg::*;

  typedef struct packed {
    logic signed [1:0] cres;
    logic              taken;
    logic [15:0]       target;
    logic              oor;
  } branch_result_t;

  branch_result_t expected_results[$];

  function automatic logic signed [1:0] float_order(logic [63:0] a, logic [63:0] b,
                                                    bit dbl, logic signed [1:0] nan_res);
    logic [63:0] sgn, expm, mask, mag, ka, kb;
    sgn  = dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    expm = dbl ? 64'h7FF0_0000_0000_0000 : 64'h7F80_0000;
    mask = dbl ? '1 : 64'hFFFF_FFFF;
    mag  = mask & ~sgn;
    a = a & mask;
    b = b & mask;
    if ((a & mag) > expm || (b & mag) > expm) return nan_res;
    if ((a & mag) == 0 && (b & mag) == 0) return CRES_EQ;
    ka = (a & sgn) != 0 ? (~a & mask) : (a | sgn);
    kb = (b & sgn) != 0 ? (~b & mask) : (b | sgn);
    if (ka > kb) return CRES_GT;
    if (ka == kb) return CRES_EQ;
    return CRES_LT;
  endfunction

  function automatic branch_result_t execute_bytecode(logic [4:0] cmd, logic [63:0] v1,
                                                      logic [63:0] v2, logic signed [15:0] off,
                                                      logic [15:0] pos);
    branch_result_t r;
    logic signed [31:0] a, b;
    logic signed [63:0] x, y;
    int sum;
    r = '0;
    a = v1[31:0];
    b = v2[31:0];
    x = v1;
    y = v2;
    case (cmd)
      CMD_LCMP:      r.cres = x > y ? CRES_GT : (x == y ? CRES_EQ : CRES_LT);
      CMD_FCMPL:     r.cres = float_order(v1, v2, 0, CRES_LT);
      CMD_FCMPG:     r.cres = float_order(v1, v2, 0, CRES_GT);
      CMD_DCMPL:     r.cres = float_order(v1, v2, 1, CRES_LT);
      CMD_DCMPG:     r.cres = float_order(v1, v2, 1, CRES_GT);
      CMD_IFEQ:      r.taken = b == 0;
      CMD_IFNE:      r.taken = b != 0;
      CMD_IFLT:      r.taken = b < 0;
      CMD_IFGE:      r.taken = b >= 0;
      CMD_IFGT:      r.taken = b > 0;
      CMD_IFLE:      r.taken = b <= 0;
      CMD_IF_ICMPEQ: r.taken = a == b;
      CMD_IF_ICMPNE: r.taken = a != b;
      CMD_IF_ICMPLT: r.taken = a < b;
      CMD_IF_ICMPGE: r.taken = a >= b;
      CMD_IF_ICMPGT: r.taken = a > b;
      CMD_IF_ICMPLE: r.taken = a <= b;
      CMD_IF_ACMPEQ: r.taken = v1 == v2;
      CMD_IF_ACMPNE: r.taken = v1 != v2;
      default: ;
    endcase
    sum = int'(pos) + int'(off);
    if (r.taken) begin
      r.target = sum[15:0];
      r.oor = sum < 0 || sum > 65535;
    end
    return r;
  endfunction

  assign pending_count = expected_results.size();

  initial begin
    fail_count = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    branch_result_t got, want;
    if (rst_n && in_valid && in_ready)
      expected_results.push_back(execute_bytecode(in_cmd, in_value_first, in_value_last,
                                                  in_branch_offset, in_insn_byte_offset));
    if (rst_n && out_valid && out_ready) begin
      got = {out_compare_result, out_branch_taken, out_target_byte_offset,
             out_target_out_of_range};
      result_count <= result_count + 1;
      if (expected_results.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10) $display("Unexpected result word %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("Mismatch: cres %0d/%0d taken %b/%b target %h/%h oor %b/%b (exp/act)",
                     want.cres, got.cres, want.taken, got.taken, want.target, got.target,
                     want.oor, got.oor);
        end
      end
    end
  end
endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JVM compare and branch unit testbench
// Drives directed and random bytecode words with bursty input and stalled
// output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import jcbu_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [CmdW-1:0] in_cmd = '0;
  logic [ValW-1:0] in_value_first = '0;
  logic [ValW-1:0] in_value_last = '0;
  logic signed [OffW-1:0] in_branch_offset = '0;
  logic [OffW-1:0] in_insn_byte_offset = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [1:0] out_compare_result;
  logic out_branch_taken;
  logic [OffW-1:0] out_target_byte_offset;
  logic out_target_out_of_range;
  int fail_count, pending_count, result_count;
  int words_sent = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  jvm_compare_branch_unit uut (.*);

  jcbu_checker chk (.*);

  function automatic logic [63:0] pick_value(bit dbl);
    logic [63:0] specials[12];
    logic [63:0] v;
    specials = '{64'h0, 64'h8000_0000, 64'h7F80_0000, 64'hFF80_0000, 64'h7FC0_0000,
                 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF, 64'h1, 64'h7FFF_FFFF_FFFF_FFFF};
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = specials[$urandom_range(11)];
      1: v = {$urandom, 32'($urandom_range(4) - 2)};
      2: if (!dbl) v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_word(logic [4:0] cmd, logic [63:0] v1, logic [63:0] v2,
                           logic [15:0] off, logic [15:0] pos);
    in_valid <= 1;
    in_cmd <= cmd;
    in_value_first <= v1;
    in_value_last <= v2;
    in_branch_offset <= off;
    in_insn_byte_offset <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  always @(posedge clk) begin
    int mode;
    mode = (words_sent / 200) % 3;
    out_ready <= mode == 0 ? 1'b1 : (mode == 1 ? ($urandom_range(3) != 0)
                                              : ($urandom_range(3) == 0));
  end

  initial begin
    logic [63:0] a, b;
    logic [4:0] cmd;
    int burst;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_word(CMD_LCMP, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0, 16'h0);
    send_word(CMD_LCMP, '1, '1, 16'h0, 16'h0);
    send_word(CMD_FCMPL, 64'h7FC0_0000, 64'h0, 16'h0, 16'h0);
    send_word(CMD_FCMPG, 64'h7FC0_0000, 64'h0, 16'h0, 16'h0);
    send_word(CMD_FCMPL, 64'hFFFF_FFFF_8000_0000, 64'h0, 16'h0, 16'h0);
    send_word(CMD_DCMPL, 64'h7FF0_0000_0000_0001, 64'h0, 16'h0, 16'h0);
    send_word(CMD_DCMPG, 64'h7FF0_0000_0000_0001, 64'h0, 16'h0, 16'h0);
    send_word(CMD_DCMPG, 64'h8000_0000_0000_0000, 64'h0, 16'h0, 16'h0);
    send_word(CMD_DCMPL, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 16'h0, 16'h0);
    for (int c = CMD_IFEQ; c <= CMD_IF_ACMPNE; c++)
      send_word(5'(c), 64'hFFFF_FFFF_0000_0005, 64'h0000_0001_0000_0005,
                c[0] ? 16'h8000 : 16'h7FFF, c[1] ? 16'hFFFF : 16'h0);
    send_word(5'd19, '1, '1, 16'h7FFF, 16'hFFFF);
    send_word(5'd31, '0, '0, 16'h8000, 16'h0);
    while (words_sent < 1420) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        cmd = $urandom_range(9) == 0 ? 5'($urandom_range(19, 31)) : 5'($urandom_range(18));
        a = pick_value(cmd == CMD_DCMPL || cmd == CMD_DCMPG);
        b = $urandom_range(3) == 0 ? a : pick_value(cmd == CMD_DCMPL || cmd == CMD_DCMPG);
        if ($urandom_range(7) == 0) b[31] = ~b[31];
        send_word(cmd, a, b, 16'($urandom), $urandom_range(1) ? 16'($urandom)
                  : ($urandom_range(1) ? 16'($urandom_range(15)) : 16'hFFF0 | 4'($urandom)));
      end
      in_valid <= 0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d bytecode words over every opcode and undefined codes; %0d results seen.",
             words_sent, result_count);
    if (fail_count == 0 && pending_count == 0)
      $display("** jvm_compare_branch_unit: PASSED **");
    else
      $display("** jvm_compare_branch_unit: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("** jvm_compare_branch_unit: FAILED **");
    $finish;
  end
endmodule
